@@ rtl/core/clutch_position_lead_lag_pwm_macros.svh @@
// ----------------------------------------------------------------------------
// Clutch controller assertion macros
// Shorthand for clocked concurrent assertions used across the clutch block.
// ----------------------------------------------------------------------------
`ifndef CLUTCH_POSITION_LEAD_LAG_PWM_MACROS_SVH
`define CLUTCH_POSITION_LEAD_LAG_PWM_MACROS_SVH

// Checked only outside reset.
`define CLPLL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define CLPLL_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/clpll_pkg.sv @@
// ----------------------------------------------------------------------------
// Clutch lead-lag package
// Field widths, register indexes, reset values and beat types of the block.
// ----------------------------------------------------------------------------
package clpll_pkg;

  localparam int unsigned POS_W      = 10;
  localparam int unsigned TGT_W      = 10;
  localparam int unsigned POLE_W     = 18;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned DRIVE_W    = 23;
  localparam int unsigned OUT_W      = 24;
  localparam int unsigned ERR_W      = 11;
  localparam int unsigned DUTY_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Accumulator: 34 fraction bits, rounded back to 16.
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned ACC_SHIFT  = 18;
  localparam int unsigned ERR_SCALE  = 10;

  localparam logic [TGT_W-1:0]   RST_HIGH_TARGET = TGT_W'(560);
  localparam logic [TGT_W-1:0]   RST_LOW_TARGET  = TGT_W'(225);
  localparam logic [POLE_W-1:0]  RST_POLE_COEFF  = POLE_W'(258413);
  localparam logic [GAIN_W-1:0]  RST_GAIN_NOW    = GAIN_W'(608564);
  localparam logic [GAIN_W-1:0]  RST_GAIN_PREV   = GAIN_W'(597247);
  localparam logic [DRIVE_W-1:0] RST_DRIVE_LIMIT = DRIVE_W'(786432);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_TARGET = 3'd0,
    REG_LOW_TARGET  = 3'd1,
    REG_POLE_COEFF  = 3'd2,
    REG_GAIN_NOW    = 3'd3,
    REG_GAIN_PREV   = 3'd4,
    REG_DRIVE_LIMIT = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [POS_W-1:0] clutch_position;
    logic             upshift_pressed;
    logic             downshift_pressed;
  } clpll_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              direction;
  } clpll_out_t;

endpackage

@@ rtl/core/clutch_position_lead_lag_pwm.sv @@
// ----------------------------------------------------------------------------
// Clutch position lead-lag controller with PWM drive
// Reference select and clamp, first-order IIR on the position error, and a
// pipelined divider that scales the drive magnitude to a PWM compare value.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one position
//   sample and the two shift buttons per beat. Output channel (out_valid_o /
//   out_ready_i / out_data_o) returns one duty and direction per input beat,
//   in order.
//   A beat passes the input register, the magnitude register, the duty
//   numerator register and the divider stages in turn. Throughput: one beat
//   per cycle while out_ready_i is not held low; the IIR state updates as the
//   sample leaves the input register, and the duty division is one quotient
//   bit per stage. Stalls: each stage holds its beat while the stage after it
//   is full and cannot move on, so a stalled receiver backs the pipeline up;
//   empty stages keep accepting until every stage holds a beat.
//   Reset: all stages empty, the configuration registers take their default
//   values, reference returns to the low target and the filter history and
//   direction clear to zero.
//   Configuration: cfg_we_i writes register cfg_idx_i from cfg_data_i in the
//   same cycle; write only while no beat is in flight.
// ----------------------------------------------------------------------------
`include "clutch_position_lead_lag_pwm_macros.svh"

module clutch_position_lead_lag_pwm #(
  parameter int unsigned PWM_PERIOD = 512
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  clpll_pkg::clpll_in_t                 in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output clpll_pkg::clpll_out_t                out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [clpll_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [clpll_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import clpll_pkg::*;

  // Quotient bits, numerator width and stage count.
  localparam int unsigned QW   = $clog2(PWM_PERIOD + 1);
  localparam int unsigned NW   = DRIVE_W + QW;
  localparam int unsigned NSTG = 3 + QW;
  localparam int unsigned LAST = NSTG - 1;
  localparam int unsigned YW   = ACC_W - ACC_SHIFT;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TGT_W-1:0]   high_target_q;
  logic [TGT_W-1:0]   low_target_q;
  logic [POLE_W-1:0]  pole_coeff_q;
  logic [GAIN_W-1:0]  gain_now_q;
  logic [GAIN_W-1:0]  gain_prev_q;
  logic [DRIVE_W-1:0] drive_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_target_q <= RST_HIGH_TARGET;
      low_target_q  <= RST_LOW_TARGET;
      pole_coeff_q  <= RST_POLE_COEFF;
      gain_now_q    <= RST_GAIN_NOW;
      gain_prev_q   <= RST_GAIN_PREV;
      drive_limit_q <= RST_DRIVE_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HIGH_TARGET: high_target_q <= cfg_data_i[TGT_W-1:0];
        REG_LOW_TARGET:  low_target_q  <= cfg_data_i[TGT_W-1:0];
        REG_POLE_COEFF:  pole_coeff_q  <= cfg_data_i[POLE_W-1:0];
        REG_GAIN_NOW:    gain_now_q    <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_PREV:   gain_prev_q   <= cfg_data_i[GAIN_W-1:0];
        REG_DRIVE_LIMIT: drive_limit_q <= cfg_data_i[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero limit behaves as one.
  logic [DRIVE_W-1:0] lim_c;
  assign lim_c = (drive_limit_q == '0) ? DRIVE_W'(1) : drive_limit_q;

  // --------------------------------------------------------------------------
  // Stage valids and backpressure
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] v_in;
  logic [NSTG-1:0] ld;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign v_in       = {v_q[NSTG-2:0], in_valid_i};
  assign ld         = v_in & rdy[NSTG-1:0];
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= ld | (v_q & ~rdy[NSTG-1:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  clpll_in_t s0_in_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s0_in_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Loop: reference, error, IIR, saturate
  // --------------------------------------------------------------------------
  logic [TGT_W-1:0]              ref_q;
  logic signed [OUT_W-1:0]       last_out_q;
  logic signed [ERR_W-1:0]       last_err_q;
  logic                          last_dir_q;

  logic [TGT_W-1:0]              ref_sel;
  logic [TGT_W-1:0]              ref_d;
  logic signed [ERR_W-1:0]       err_d;
  logic signed [POLE_W:0]        pole_s;
  logic signed [GAIN_W:0]        gain_now_s;
  logic signed [GAIN_W:0]        gain_prev_s;
  logic signed [POLE_W+OUT_W:0]  prod_pole;
  logic signed [GAIN_W+ERR_W:0]  prod_now;
  logic signed [GAIN_W+ERR_W:0]  prod_prev;
  logic signed [GAIN_W+ERR_W+1:0] err_term;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-ACC_SHIFT-1:0] y_full;
  logic signed [OUT_W-1:0]       y_sat;
  logic                          dir_d;
  logic [OUT_W-1:0]              mag_full;
  logic [DRIVE_W-1:0]            mag;
  logic                          adv0;

  assign adv0 = ld[1];

  always_comb begin
    if (s0_in_q.upshift_pressed) begin
      ref_sel = high_target_q;
    end else if (s0_in_q.downshift_pressed) begin
      ref_sel = low_target_q;
    end else begin
      ref_sel = ref_q;
    end
    // Upper clamp first, so an inverted pair gives high above it, else low.
    if (ref_sel > high_target_q) begin
      ref_d = high_target_q;
    end else if (ref_sel < low_target_q) begin
      ref_d = low_target_q;
    end else begin
      ref_d = ref_sel;
    end

    err_d = signed'({1'b0, ref_d}) - signed'({1'b0, s0_in_q.clutch_position});

    pole_s      = signed'({1'b0, pole_coeff_q});
    gain_now_s  = signed'({1'b0, gain_now_q});
    gain_prev_s = signed'({1'b0, gain_prev_q});
    prod_pole   = (POLE_W+OUT_W+1)'(pole_s) * (POLE_W+OUT_W+1)'(last_out_q);
    prod_now    = (GAIN_W+ERR_W+1)'(gain_now_s) * (GAIN_W+ERR_W+1)'(err_d);
    prod_prev   = (GAIN_W+ERR_W+1)'(gain_prev_s) * (GAIN_W+ERR_W+1)'(last_err_q);
    err_term    = (GAIN_W+ERR_W+2)'(prod_now) - (GAIN_W+ERR_W+2)'(prod_prev);

    // Round half up to Q8.16, then saturate.
    acc = ACC_W'(prod_pole) + (ACC_W'(err_term) <<< ERR_SCALE)
        + (ACC_W'(1) <<< (ACC_SHIFT - 1));
    y_full = acc[ACC_W-1:ACC_SHIFT];
    if (y_full[YW-1:OUT_W-1] != {(YW-OUT_W+1){y_full[YW-1]}}) begin
      y_sat = y_full[YW-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                           : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      y_sat = y_full[OUT_W-1:0];
    end

    // Hold direction on a zero output.
    if (y_sat == '0) begin
      dir_d = last_dir_q;
    end else begin
      dir_d = !y_sat[OUT_W-1];
    end

    mag_full = y_sat[OUT_W-1] ? (~y_sat + OUT_W'(1)) : y_sat;
    if (mag_full > {1'b0, lim_c}) begin
      mag = lim_c;
    end else begin
      mag = mag_full[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q      <= RST_LOW_TARGET;
      last_out_q <= '0;
      last_err_q <= '0;
      last_dir_q <= 1'b0;
    end else if (adv0) begin
      ref_q      <= ref_d;
      last_out_q <= y_sat;
      last_err_q <= err_d;
      last_dir_q <= dir_d;
    end
  end

  // --------------------------------------------------------------------------
  // Magnitude register and duty numerator
  // --------------------------------------------------------------------------
  logic [DRIVE_W-1:0] s1_mag_q;
  logic               s1_dir_q;
  logic [NW-1:0]      s2_num_q;
  logic               s2_dir_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      s1_mag_q <= mag;
      s1_dir_q <= dir_d;
    end
    if (ld[2]) begin
      s2_num_q <= NW'(s1_mag_q) * NW'(PWM_PERIOD);
      s2_dir_q <= s1_dir_q;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage, most significant first
  // --------------------------------------------------------------------------
  logic [NW-1:0] div_rem_q [QW];
  logic [QW-1:0] div_quo_q [QW];
  logic          div_dir_q [QW];
  logic [NW-1:0] rin [QW];
  logic [QW-1:0] qin [QW];
  logic          din [QW];
  logic [NW-1:0] div_rem_d [QW];
  logic [QW-1:0] div_quo_d [QW];

  always_comb begin
    rin[0] = s2_num_q;
    qin[0] = '0;
    din[0] = s2_dir_q;
    for (int d = 1; d < QW; d++) begin
      rin[d] = div_rem_q[d-1];
      qin[d] = div_quo_q[d-1];
      din[d] = div_dir_q[d-1];
    end
    for (int d = 0; d < QW; d++) begin
      if (rin[d] >= (NW'(lim_c) << (QW - 1 - d))) begin
        div_rem_d[d] = rin[d] - (NW'(lim_c) << (QW - 1 - d));
        div_quo_d[d] = qin[d] | (QW'(1) << (QW - 1 - d));
      end else begin
        div_rem_d[d] = rin[d];
        div_quo_d[d] = qin[d];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < QW; d++) begin
      if (ld[3+d]) begin
        div_rem_q[d] <= div_rem_d[d];
        div_quo_q[d] <= div_quo_d[d];
        div_dir_q[d] <= din[d];
      end
    end
  end

  assign out_valid_o          = v_q[LAST];
  assign out_data_o.duty      = DUTY_W'(div_quo_q[QW-1]);
  assign out_data_o.direction = div_dir_q[QW-1];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CLPLL_ASSERT_RST(a_reset_empty, !rst_ni |=> (v_q == '0), "pipeline not empty in reset")
  `CLPLL_ASSERT(a_duty_bound, v_q[LAST] |-> (div_quo_q[QW-1] <= QW'(PWM_PERIOD)), "duty above period")
  `CLPLL_ASSERT(a_rem_bound, v_q[LAST] |-> (div_rem_q[QW-1] < NW'(lim_c)), "divider remainder too large")
  `CLPLL_ASSERT(a_state_hold, !adv0 |=> ($stable(last_out_q) && $stable(ref_q)), "loop state moved without a beat")
  `CLPLL_ASSERT(a_dir_zero, (adv0 && (y_sat == '0)) |=> (last_dir_q == $past(last_dir_q)), "direction changed on zero output")

endmodule

@@ sim/clutch_position_lead_lag_pwm_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clutch position lead-lag controller testbench
// Drives position samples and shift buttons through the valid/ready input
// channel. Random gaps and receiver stalls are applied, and the block is
// reprogrammed between drained phases. A scoreboard predicts the target
// select and clamp, the rounded and saturated IIR output and the duty/direction
// pair, then checks every output beat in order.
// ----------------------------------------------------------------------------
module clutch_position_lead_lag_pwm_test;
  import clpll_pkg::*;

  localparam int unsigned PWM_PERIOD      = 512;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 135;
  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  localparam int unsigned POS_MAX         = 2**POS_W - 1;
  localparam int unsigned TGT_MAX         = 2**TGT_W - 1;
  localparam int unsigned POLE_MAX        = 2**POLE_W - 1;
  localparam int unsigned GAIN_MAX        = 2**GAIN_W - 1;
  localparam int unsigned DRIVE_MAX       = 2**DRIVE_W - 1;
  localparam longint      Y_MAX           = 2**(OUT_W-1) - 1;
  localparam longint      Y_MIN           = -(2**(OUT_W-1));

  typedef struct {
    logic [TGT_W-1:0]   high_tgt;
    logic [TGT_W-1:0]   low_tgt;
    logic [POLE_W-1:0]  pole;
    logic [GAIN_W-1:0]  g_now;
    logic [GAIN_W-1:0]  g_prev;
    logic [DRIVE_W-1:0] limit;
  } reg_set_t;

  class drive_checker;
    logic [TGT_W-1:0]          high_tgt;
    logic [TGT_W-1:0]          low_tgt;
    logic [POLE_W-1:0]         pole;
    logic [GAIN_W-1:0]         g_now;
    logic [GAIN_W-1:0]         g_prev;
    logic [DRIVE_W-1:0]        limit;
    logic [TGT_W-1:0]          ref_pos;
    logic signed [OUT_W-1:0]   y_prev;
    logic signed [ERR_W-1:0]   e_prev;
    logic                      dir;
    clpll_out_t                pending_drive[$];
    int unsigned               failures;

    function new();
      high_tgt = RST_HIGH_TARGET;
      low_tgt  = RST_LOW_TARGET;
      pole     = RST_POLE_COEFF;
      g_now    = RST_GAIN_NOW;
      g_prev   = RST_GAIN_PREV;
      limit    = RST_DRIVE_LIMIT;
      ref_pos  = RST_LOW_TARGET;
      y_prev   = '0;
      e_prev   = '0;
      dir      = 1'b0;
      failures = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_HIGH_TARGET: high_tgt = TGT_W'(val);
        REG_LOW_TARGET:  low_tgt  = TGT_W'(val);
        REG_POLE_COEFF:  pole     = POLE_W'(val);
        REG_GAIN_NOW:    g_now    = GAIN_W'(val);
        REG_GAIN_PREV:   g_prev   = GAIN_W'(val);
        REG_DRIVE_LIMIT: limit    = DRIVE_W'(val);
        default: ;
      endcase
    endfunction

    function clpll_out_t predict_drive(clpll_in_t beat);
      longint     err;
      longint     acc;
      longint     y;
      longint     mag;
      longint     lim;
      longint     duty_full;
      clpll_out_t res;
      if (beat.upshift_pressed) begin
        ref_pos = high_tgt;
      end else if (beat.downshift_pressed) begin
        ref_pos = low_tgt;
      end
      // Upper clamp first: with an inverted pair, a reference above the high target takes it, any other the low target
      if (ref_pos > high_tgt) begin
        ref_pos = high_tgt;
      end else if (ref_pos < low_tgt) begin
        ref_pos = low_tgt;
      end
      err = longint'(ref_pos) - longint'(beat.clutch_position);
      acc = longint'(pole) * longint'(y_prev)
          + (longint'(g_now) * err - longint'(g_prev) * longint'(e_prev)) * 1024;
      // Round half up to Q8.16, then saturate
      y = (acc + (longint'(1) << 17)) >>> ACC_SHIFT;
      if (y > Y_MAX) begin
        y = Y_MAX;
      end else if (y < Y_MIN) begin
        y = Y_MIN;
      end
      if (y > 0) begin
        dir = 1'b1;
      end else if (y < 0) begin
        dir = 1'b0;
      end
      mag = (y < 0) ? -y : y;
      lim = (limit == '0) ? longint'(1) : longint'(limit);
      if (mag > lim) begin
        mag = lim;
      end
      duty_full = (mag * longint'(PWM_PERIOD)) / lim;
      y_prev = OUT_W'(y);
      e_prev = ERR_W'(err);
      res.duty = DUTY_W'(duty_full);
      res.direction = dir;
      return res;
    endfunction

    function void note_input(clpll_in_t beat);
      pending_drive.push_back(predict_drive(beat));
    endfunction

    function void check_result(clpll_out_t got);
      clpll_out_t want;
      if (pending_drive.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got duty %0d direction %0d",
                 $time, got.duty, got.direction);
        failures++;
        return;
      end
      want = pending_drive.pop_front();
      if (got.duty !== want.duty) begin
        $display("%0t: duty mismatch, expected %0d, got %0d", $time, want.duty, got.duty);
        failures++;
      end
      if (got.direction !== want.direction) begin
        $display("%0t: direction mismatch, expected %0d, got %0d",
                 $time, want.direction, got.direction);
        failures++;
      end
    endfunction

    function bit busy();
      return pending_drive.size() != 0;
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  clpll_in_t             in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  clpll_out_t            out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  drive_checker sb = new();
  bit           tx_gap_on   = 1'b1;
  bit           rx_stall_on = 1'b1;
  int unsigned  rx_hold     = 0;
  int unsigned  quiet_cycles = 0;

  clutch_position_lead_lag_pwm #(
    .PWM_PERIOD(PWM_PERIOD)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Receiver: check each beat, then hold ready low for a drawn stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_data_o);
        rx_hold = rx_stall_on ? $urandom_range(0, 17) : 0;
      end
      if (rx_hold != 0) begin
        out_ready_i <= 1'b0;
        rx_hold = rx_hold - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("clutch_position_lead_lag_pwm test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input clpll_in_t beat);
    int unsigned gap;
    gap = tx_gap_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(beat);
  endtask

  // Drop valid and wait for every predicted beat to come back
  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    while (sb.busy()) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic program_regs(input reg_set_t r);
    write_reg(REG_HIGH_TARGET, CFG_DATA_W'(r.high_tgt));
    write_reg(REG_LOW_TARGET,  CFG_DATA_W'(r.low_tgt));
    write_reg(REG_POLE_COEFF,  CFG_DATA_W'(r.pole));
    write_reg(REG_GAIN_NOW,    CFG_DATA_W'(r.g_now));
    write_reg(REG_GAIN_PREV,   CFG_DATA_W'(r.g_prev));
    write_reg(REG_DRIVE_LIMIT, CFG_DATA_W'(r.limit));
    cfg_we_i <= 1'b0;
  endtask

  function automatic clpll_in_t make_beat(int unsigned pos, bit up, bit down);
    clpll_in_t b;
    b.clutch_position   = POS_W'(pos);
    b.upshift_pressed   = up;
    b.downshift_pressed = down;
    return b;
  endfunction

  function automatic reg_set_t reset_regs();
    reg_set_t r;
    r.high_tgt = RST_HIGH_TARGET;
    r.low_tgt  = RST_LOW_TARGET;
    r.pole     = RST_POLE_COEFF;
    r.g_now    = RST_GAIN_NOW;
    r.g_prev   = RST_GAIN_PREV;
    r.limit    = RST_DRIVE_LIMIT;
    return r;
  endfunction

  function automatic reg_set_t random_regs();
    reg_set_t    r;
    int unsigned a;
    int unsigned b;
    a = $urandom_range(0, TGT_MAX);
    b = $urandom_range(0, TGT_MAX);
    // Mostly an ordered target pair, now and then an inverted one
    if ((a > b) != ($urandom_range(0, 4) == 0)) begin
      r.high_tgt = TGT_W'(a);
      r.low_tgt  = TGT_W'(b);
    end else begin
      r.high_tgt = TGT_W'(b);
      r.low_tgt  = TGT_W'(a);
    end
    case ($urandom_range(0, 5))
      0:       r.pole = '0;
      1:       r.pole = POLE_W'(POLE_MAX);
      2:       r.pole = POLE_W'($urandom_range(0, POLE_MAX));
      default: r.pole = POLE_W'($urandom_range(POLE_MAX - 16384, POLE_MAX));
    endcase
    case ($urandom_range(0, 5))
      0:       r.g_now = '0;
      1:       r.g_now = GAIN_W'(GAIN_MAX);
      2:       r.g_now = GAIN_W'($urandom_range(0, GAIN_MAX));
      default: r.g_now = GAIN_W'($urandom_range(0, 2000000));
    endcase
    case ($urandom_range(0, 4))
      0:       r.g_prev = GAIN_W'(GAIN_MAX);
      1:       r.g_prev = GAIN_W'($urandom_range(0, GAIN_MAX));
      default: r.g_prev = (r.g_now > 20000) ? r.g_now - GAIN_W'($urandom_range(0, 20000)) : '0;
    endcase
    case ($urandom_range(0, 5))
      0:       r.limit = DRIVE_W'(1);
      1:       r.limit = DRIVE_W'(DRIVE_MAX);
      2:       r.limit = DRIVE_W'($urandom_range(1, DRIVE_MAX));
      default: r.limit = DRIVE_W'($urandom_range(65536, 2000000));
    endcase
    return r;
  endfunction

  function automatic clpll_in_t random_sample();
    clpll_in_t   b;
    int unsigned k;
    int          pos;
    k = $urandom_range(0, 99);
    if (k < 5) begin
      pos = 0;
    end else if (k < 10) begin
      pos = POS_MAX;
    end else if (k < 35) begin
      // Track the present target so the loop sees small errors
      pos = int'(sb.ref_pos) + $urandom_range(0, 80) - 40;
      pos = (pos < 0) ? 0 : (pos > int'(POS_MAX)) ? int'(POS_MAX) : pos;
    end else begin
      pos = $urandom_range(0, POS_MAX);
    end
    k = $urandom_range(0, 99);
    b.clutch_position   = POS_W'(pos);
    b.upshift_pressed   = (k < 15) || (k >= 95);
    b.downshift_pressed = (k >= 15 && k < 25) || (k >= 95);
    return b;
  endfunction

  initial begin
    reg_set_t    r;
    int unsigned p;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings; a centred first sample gives zero output
    send_beat(make_beat(225, 1'b0, 1'b0));
    send_beat(make_beat(0, 1'b0, 1'b0));
    send_beat(make_beat(POS_MAX, 1'b0, 1'b0));
    send_beat(make_beat(560, 1'b1, 1'b0));
    send_beat(make_beat(0, 1'b1, 1'b1));
    send_beat(make_beat(POS_MAX, 1'b0, 1'b1));
    send_beat(make_beat(0, 1'b0, 1'b1));
    send_beat(make_beat(512, 1'b0, 1'b0));
    settle_pipeline();

    // Inverted targets, full pole and present-error gain, no previous-error gain, full drive: saturate both ways
    r.high_tgt = TGT_W'(100);
    r.low_tgt  = TGT_W'(900);
    r.pole     = POLE_W'(POLE_MAX);
    r.g_now    = GAIN_W'(GAIN_MAX);
    r.g_prev   = '0;
    r.limit    = DRIVE_W'(DRIVE_MAX);
    program_regs(r);
    send_beat(make_beat(0, 1'b1, 1'b0));
    send_beat(make_beat(POS_MAX, 1'b0, 1'b1));
    send_beat(make_beat(500, 1'b0, 1'b0));
    send_beat(make_beat(POS_MAX, 1'b1, 1'b1));
    settle_pipeline();

    // All weights zero: output stays zero and direction holds; zero drive limit
    r.high_tgt = TGT_W'(TGT_MAX);
    r.low_tgt  = '0;
    r.pole     = '0;
    r.g_now    = '0;
    r.g_prev   = '0;
    r.limit    = '0;
    program_regs(r);
    send_beat(make_beat(0, 1'b1, 1'b0));
    send_beat(make_beat(POS_MAX, 1'b0, 1'b1));
    send_beat(make_beat(0, 1'b0, 1'b0));
    settle_pipeline();

    // Smallest drive limit with a heavy previous-error weight
    r.g_now  = GAIN_W'(1);
    r.g_prev = GAIN_W'(GAIN_MAX);
    r.limit  = DRIVE_W'(1);
    program_regs(r);
    send_beat(make_beat(0, 1'b0, 1'b1));
    send_beat(make_beat(POS_MAX, 1'b1, 1'b0));
    send_beat(make_beat(0, 1'b1, 1'b1));
    send_beat(make_beat(POS_MAX, 1'b0, 1'b0));
    settle_pipeline();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      tx_gap_on   = (p % 3) != 0;
      rx_stall_on = (p % 4) != 1;
      r = (p == 0) ? reset_regs() : random_regs();
      program_regs(r);
      repeat (ITEMS_PER_PHASE) send_beat(random_sample());
      settle_pipeline();
    end

    repeat (16) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("clutch_position_lead_lag_pwm test passed");
    end else begin
      $display("clutch_position_lead_lag_pwm test failed");
    end
    $finish;
  end

endmodule
